/* rtl/nonzero_balanced_row_partitioner_defines.svh */
// assertion macros for the checker file
`ifndef NONZERO_BALANCED_ROW_PARTITIONER_DEFINES_SVH
`define NONZERO_BALANCED_ROW_PARTITIONER_DEFINES_SVH

// same-cycle implication, off while in reset
`define NBRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, off while in reset
`define NBRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/nbrp_pkg.sv */
// shared types and constants of the nonzero balanced row partitioner
package nbrp_pkg;

    localparam int OFFSET_W   = 32;
    localparam int CUT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEP_W = $clog2(OFFSET_W);

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_NONZEROS = 2'd1;

    // quotient and remainder of total_nonzeros over the block count, with busy and done flags
    typedef struct packed {
        logic [OFFSET_W-1:0] quotient;
        logic [CUT_W-1:0]    remainder;
        logic                busy;
        logic                done;
    } div_result_t;

endpackage

/* rtl/nbrp_if.sv */
// valid/ready channels for row offsets in and cut points out
interface nbrp_in_if;
    logic                          valid;
    logic                          ready;
    logic [nbrp_pkg::OFFSET_W-1:0] row_end_offset;
    logic                          final_row;

    modport source (output valid, output row_end_offset, output final_row, input ready);
    modport sink   (input valid, input row_end_offset, input final_row, output ready);
endinterface

interface nbrp_out_if #(
    parameter int ROW_W = 25
);
    logic                       valid;
    logic                       ready;
    logic [nbrp_pkg::CUT_W-1:0] cut_number;
    logic [ROW_W-1:0]           cut_row;
    logic                       last_cut;

    modport source (output valid, output cut_number, output cut_row, output last_cut,
                    input ready);
    modport sink   (input valid, input cut_number, input cut_row, input last_cut,
                    output ready);
endinterface

/* rtl/nbrp_div.sv */
// bit-serial divider: total nonzeros over block count, one quotient bit per cycle
module nbrp_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nbrp_pkg::OFFSET_W-1:0] dividend,
    input  logic [nbrp_pkg::CUT_W-1:0]    divisor,
    output nbrp_pkg::div_result_t         result
);

    localparam int OW = nbrp_pkg::OFFSET_W;
    localparam int CW = nbrp_pkg::CUT_W;

    logic [OW-1:0]                   quot_reg, quot_next;
    logic [CW-1:0]                   rem_reg, rem_next;
    logic [nbrp_pkg::DIV_STEP_W-1:0] step_reg, step_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [CW-1:0]                   trial;
    logic                            fits;

    // remainder stays below the divisor, so its top bit is free for the shift
    assign trial = {rem_reg[CW-2:0], quot_reg[OW-1]};
    assign fits  = (trial >= divisor);

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[OW-2:0], fits};
            rem_next  = fits ? (trial - divisor) : trial;
            step_next = step_reg + 1'b1;
            if (step_reg == nbrp_pkg::DIV_STEP_W'(OW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign result.quotient  = quot_reg;
    assign result.remainder = rem_reg;
    assign result.busy      = busy_reg;
    assign result.done      = done_reg;

endmodule

/* rtl/nbrp_fifo.sv */
// small register queue between the row front end and the cut engine
module nbrp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign pop_data = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/nbrp_front.sv */
// input side: takes row offsets, numbers the rows and queues them for the cut engine
module nbrp_front #(
    parameter longint unsigned MAX_ROWS = 64'd16777216,
    parameter int              ROW_W    = 25
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    nbrp_in_if.sink                               in_ch,
    input  logic                                  restart,
    input  logic                                  hold,
    input  logic                                  queue_full,
    output logic                                  push,
    output logic [nbrp_pkg::OFFSET_W+2*ROW_W:0]   push_data
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] tail_row;
    logic             at_limit;

    assign at_limit    = (row_reg >= ROW_W'(MAX_ROWS));
    // row count seen on the final row, saturated at the row limit
    assign tail_row    = at_limit ? ROW_W'(MAX_ROWS) : row_reg + 1'b1;

    assign in_ch.ready = !queue_full && !hold;
    assign push        = in_ch.valid && in_ch.ready;
    assign push_data   = {in_ch.row_end_offset, in_ch.final_row, row_reg, tail_row};

    always_comb
    begin
        row_next = row_reg;
        if (restart)
        begin
            row_next = '0;
        end
        else if (push)
        begin
            if (in_ch.final_row)
            begin
                row_next = '0;
            end
            else if (!at_limit)
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/nbrp_back.sv */
// cut engine: compares queued rows against cut targets and emits cut points
module nbrp_back #(
    parameter int ROW_W = 25
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                queue_empty,
    input  logic [nbrp_pkg::OFFSET_W+2*ROW_W:0] queue_data,
    output logic                                pop,
    input  logic [nbrp_pkg::CUT_W-1:0]          blocks,
    input  nbrp_pkg::div_result_t               div,
    nbrp_out_if.source                          out_ch
);

    localparam int OW = nbrp_pkg::OFFSET_W;
    localparam int CW = nbrp_pkg::CUT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL
    } state_t;

    state_t           state_reg, state_next;
    logic [OW-1:0]    offset_reg, offset_next;
    logic             final_reg, final_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] tail_reg, tail_next;
    logic [CW-1:0]    cut_reg, cut_next;
    logic [OW-1:0]    target_reg, target_next;
    logic [CW-1:0]    acc_reg, acc_next;
    logic             out_valid_reg, out_valid_next;
    logic [CW-1:0]    out_cut_reg, out_cut_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             out_last_reg, out_last_next;

    logic             slot_free;
    logic             cut_hit;
    logic [CW:0]      acc_sum;
    logic             wrap;
    logic [CW-1:0]    acc_adv;
    logic [OW-1:0]    target_adv;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign cut_hit   = (cut_reg < blocks) && (offset_reg >= target_reg);

    // target of cut c+1 = target of cut c + q + carry of the running remainder
    assign acc_sum    = {1'b0, acc_reg} + {1'b0, div.remainder};
    assign wrap       = (acc_sum >= {1'b0, blocks});
    assign acc_adv    = wrap ? CW'(acc_sum - {1'b0, blocks}) : CW'(acc_sum);
    assign target_adv = target_reg + div.quotient + OW'(wrap);

    always_comb
    begin
        state_next     = state_reg;
        offset_next    = offset_reg;
        final_next     = final_reg;
        row_next       = row_reg;
        tail_next      = tail_reg;
        cut_next       = cut_reg;
        target_next    = target_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_cut_next   = out_cut_reg;
        out_row_next   = out_row_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;

        if (div.done)
        begin
            // new configuration: restart at cut one
            state_next  = ST_IDLE;
            cut_next    = CW'(1);
            target_next = div.quotient;
            acc_next    = div.remainder;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        pop = 1'b1;
                        {offset_next, final_next, row_next, tail_next} = queue_data;
                        state_next = ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (cut_hit)
                    begin
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            out_cut_next   = cut_reg;
                            out_row_next   = row_reg;
                            out_last_next  = 1'b0;
                            cut_next       = cut_reg + 1'b1;
                            target_next    = target_adv;
                            acc_next       = acc_adv;
                        end
                    end
                    else if (final_reg)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_TAIL:
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_cut_next   = cut_reg;
                        out_row_next   = tail_reg;
                        out_last_next  = (cut_reg == blocks);
                        if (cut_reg == blocks)
                        begin
                            // matrix done, next row starts a new partition
                            state_next  = ST_IDLE;
                            cut_next    = CW'(1);
                            target_next = div.quotient;
                            acc_next    = div.remainder;
                        end
                        else
                        begin
                            cut_next = cut_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            final_reg     <= 1'b0;
            row_reg       <= '0;
            tail_reg      <= '0;
            cut_reg       <= CW'(1);
            target_reg    <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_cut_reg   <= '0;
            out_row_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            final_reg     <= final_next;
            row_reg       <= row_next;
            tail_reg      <= tail_next;
            cut_reg       <= cut_next;
            target_reg    <= target_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_cut_reg   <= out_cut_next;
            out_row_reg   <= out_row_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.cut_number = out_cut_reg;
    assign out_ch.cut_row    = out_row_reg;
    assign out_ch.last_cut   = out_last_reg;

endmodule

/* rtl/nonzero_balanced_row_partitioner.sv */
// top level: splits sparse matrix rows into blocks of near-equal nonzero count
// Rows arrive as cumulative end offsets, one per transfer, and are queued (four deep)
// ahead of the cut engine, which pops a row in its idle state and then compares it in
// its scan state, emitting that row's cut points one after another and holding while
// the output slot is occupied. The last row emits every pending cut up to cut block_count,
// each with the row count as its row. A write to block_count or total_nonzeros
// restarts the partition and starts a bit-serial divider for the per-cut step; input
// is held off while that start is pending and while the divider is busy. cut_row is
// clog2(MAX_ROWS+1) bits wide and the out channel must be built with that ROW_W.
// Configuration is to be written only while the block is idle.
module nonzero_balanced_row_partitioner #(
    parameter int              MAX_BLOCKS = 64,
    parameter longint unsigned MAX_ROWS   = 64'd16777216
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    nbrp_in_if.sink                         in_ch,
    nbrp_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [nbrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nbrp_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ROW_W   = $clog2(MAX_ROWS + 64'd1);
    localparam int OW      = nbrp_pkg::OFFSET_W;
    localparam int CW      = nbrp_pkg::CUT_W;
    localparam int ENTRY_W = OW + 2 * ROW_W + 1;

    logic [CW-1:0]         block_count_reg;
    logic [OW-1:0]         total_reg;
    logic                  div_start_reg;
    logic                  cfg_hit;
    logic [CW-1:0]         blocks;
    nbrp_pkg::div_result_t div;
    logic                  push, pop, q_empty, q_full;
    logic [ENTRY_W-1:0]    push_data, pop_data;

    assign cfg_hit = cfg_we && ((cfg_index == nbrp_pkg::REG_BLOCK_COUNT) ||
                                (cfg_index == nbrp_pkg::REG_TOTAL_NONZEROS));

    // block count zero acts as one, above the limit saturates
    assign blocks = (block_count_reg == '0) ? CW'(1) :
                    (block_count_reg > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : block_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= CW'(1);
            total_reg       <= '0;
            div_start_reg   <= 1'b0;
        end
        else
        begin
            div_start_reg <= cfg_hit;
            if (cfg_we && (cfg_index == nbrp_pkg::REG_BLOCK_COUNT))
            begin
                block_count_reg <= cfg_data[CW-1:0];
            end
            if (cfg_we && (cfg_index == nbrp_pkg::REG_TOTAL_NONZEROS))
            begin
                total_reg <= cfg_data[OW-1:0];
            end
        end
    end

    nbrp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (total_reg),
        .divisor  (blocks),
        .result   (div)
    );

    nbrp_front #(
        .MAX_ROWS (MAX_ROWS),
        .ROW_W    (ROW_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .restart    (cfg_hit),
        .hold       (div_start_reg || div.busy),
        .queue_full (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    nbrp_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (nbrp_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    nbrp_back #(
        .ROW_W (ROW_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .blocks      (blocks),
        .div         (div),
        .out_ch      (out_ch)
    );

endmodule

/* rtl/nbrp_checker.sv */
// port-level checks for the row partitioner, bound to the top level
`include "nonzero_balanced_row_partitioner_defines.svh"

module nbrp_checker #(
    parameter int MAX_BLOCKS = 64,
    parameter int ROW_W      = 25
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [nbrp_pkg::CUT_W-1:0]     cut_number,
    input logic [ROW_W-1:0]               cut_row,
    input logic                           last_cut,
    input logic                           cfg_we,
    input logic [nbrp_pkg::CFG_IDX_W-1:0] cfg_index
);

    // a stalled cut point holds its payload
    `NBRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(cut_number) && $stable(cut_row) && $stable(last_cut))

    // cut numbers run from one to the block limit
    `NBRP_ASSERT_IMPL(a_cut_range, clk, rst_n, out_valid,
        (cut_number != '0) && (cut_number <= nbrp_pkg::CUT_W'(MAX_BLOCKS)))

    // back-to-back cuts of one partition count up by one
    `NBRP_ASSERT_IMPL(a_cut_seq, clk, rst_n, (out_valid && out_ready && !last_cut) ##1 out_valid,
        cut_number == nbrp_pkg::CUT_W'($past(cut_number) + 1'b1))

    // a register write holds off input while the step is recomputed
    `NBRP_ASSERT_NEXT(a_cfg_hold, clk, rst_n,
        cfg_we && ((cfg_index == nbrp_pkg::REG_BLOCK_COUNT) ||
                   (cfg_index == nbrp_pkg::REG_TOTAL_NONZEROS)),
        !in_ready)

endmodule

bind nonzero_balanced_row_partitioner nbrp_checker #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ROW_W      (ROW_W)
) u_nbrp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cut_number (out_ch.cut_number),
    .cut_row    (out_ch.cut_row),
    .last_cut   (out_ch.last_cut),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index)
);
